FILE: rtl/core/kl_pkg.sv
// shared constants and tables for the keyword lexer
`timescale 1ns / 1ps

package kl_pkg;

    localparam int KIND_W     = 5;
    localparam int NUM_KW     = 6;
    localparam int KW_SLOTS   = 8;
    localparam int NUM_OP     = 11;
    localparam int MAX_RES    = 3;

    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_STRING  = 5'd8;
    localparam logic [KIND_W-1:0] KIND_OP_BASE = 5'd9;
    localparam logic [KIND_W-1:0] KIND_EOF     = 5'd20;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd21;

    localparam logic [NUM_KW-1:0] ALL_CANDIDATES = 6'h3F;

    // keyword text, zero padded; row index is the keyword kind
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t",   8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e",   8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd4, 3'd5, 3'd3, 3'd2, 3'd5};

    localparam logic [7:0] OP_CHARS [NUM_OP] = '{
        "(", ")", "{", "}", ";", ",", "=", "+", "-", "*", "/"
    };

    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

endpackage

FILE: rtl/core/kl_if.sv
// byte and token channel interfaces for the keyword lexer
`timescale 1ns / 1ps

interface kl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_byte;

    modport source (output valid, output ch, output final_byte, input ready);
    modport sink   (input valid, input ch, input final_byte, output ready);
endinterface

interface kl_token_if #(
    parameter int POS_W = 20,
    parameter int LEN_W = 8
);
    logic                      valid;
    logic                      ready;
    logic [kl_pkg::KIND_W-1:0] kind;
    logic [POS_W-1:0]          start_res;
    logic [LEN_W-1:0]          length;
    logic [7:0]                char_value;
    logic                      too_long;
    logic                      run_end;

    modport source (output valid, output kind, output start_res, output length,
                    output char_value, output too_long, output run_end, input ready);
    modport sink   (input valid, input kind, input start_res, input length,
                    input char_value, input too_long, input run_end, output ready);
endinterface

FILE: rtl/core/kl_scanner.sv
// scanner state and per-byte token classification
`timescale 1ns / 1ps

module kl_scanner #(
    parameter int POS_W   = 20,
    parameter int MAX_LEN = 255,
    parameter int LEN_W   = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                ch,
    input  logic                      final_byte,
    output logic [1:0]                res_count,
    output logic [kl_pkg::KIND_W-1:0] res_kind  [kl_pkg::MAX_RES],
    output logic [POS_W-1:0]          res_start [kl_pkg::MAX_RES],
    output logic [LEN_W-1:0]          res_len   [kl_pkg::MAX_RES],
    output logic [7:0]                res_cv    [kl_pkg::MAX_RES],
    output logic                      res_tl    [kl_pkg::MAX_RES]
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_STRING = 2'd3
    } mode_t;

    mode_t                      mode_reg, mode_next;
    logic [POS_W-1:0]           start_reg, start_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       ovf_reg, ovf_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [kl_pkg::NUM_KW-1:0]  cand_reg, cand_next;

    logic [POS_W-1:0]           pos_inc;
    logic                       do_ext, do_pend, do_fresh;
    logic [1:0]                 n;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == kl_pkg::CH_UNDERSCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    // drop keywords whose character at this index differs or that end before this index
    function automatic logic [kl_pkg::NUM_KW-1:0] filter(
        input logic [kl_pkg::NUM_KW-1:0] cands,
        input logic [LEN_W-1:0]          idx,
        input logic [7:0]                c
    );
        logic [kl_pkg::NUM_KW-1:0] r;
        r = cands;
        for (int k = 0; k < kl_pkg::NUM_KW; k++) begin
            if (idx >= LEN_W'(kl_pkg::KW_LEN[k]) || kl_pkg::KW_TEXT[k][idx[2:0]] != c)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [kl_pkg::KIND_W-1:0] pending_kind(
        input mode_t                     m,
        input logic                      ov,
        input logic [kl_pkg::NUM_KW-1:0] cands,
        input logic [LEN_W-1:0]          len
    );
        logic [kl_pkg::KIND_W-1:0] r;
        r = kl_pkg::KIND_STRING;
        if (m == MODE_NUMBER)
        begin
            r = kl_pkg::KIND_NUMBER;
        end
        else if (m == MODE_IDENT)
        begin
            r = kl_pkg::KIND_IDENT;
            if (!ov)
            begin
                for (int k = 0; k < kl_pkg::NUM_KW; k++) begin
                    if (cands[k] && LEN_W'(kl_pkg::KW_LEN[k]) == len)
                    begin
                        r = kl_pkg::KIND_W'(k);
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic [kl_pkg::KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [kl_pkg::KIND_W-1:0] r;
        r = kl_pkg::KIND_UNKNOWN;
        for (int k = 0; k < kl_pkg::NUM_OP; k++) begin
            if (kl_pkg::OP_CHARS[k] == c)
            begin
                r = kl_pkg::KIND_OP_BASE + kl_pkg::KIND_W'(k);
            end
        end
        return r;
    endfunction

    assign pos_inc = pos_reg + 1'b1;

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        cand_next  = cand_reg;
        pos_next   = pos_inc;
        do_ext     = 1'b0;
        do_pend    = 1'b0;
        do_fresh   = 1'b0;
        n          = 2'd0;
        for (int i = 0; i < kl_pkg::MAX_RES; i++) begin
            res_kind[i]  = '0;
            res_start[i] = '0;
            res_len[i]   = '0;
            res_cv[i]    = '0;
            res_tl[i]    = 1'b0;
        end

        case (mode_reg)
            MODE_IDENT:
            begin
                if (is_ident(ch)) do_ext = 1'b1;
                else
                begin
                    do_pend  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(ch)) do_ext = 1'b1;
                else
                begin
                    do_pend  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (ch == kl_pkg::CH_QUOTE) do_pend = 1'b1;
                else                        do_ext  = 1'b1;
            end
            default: do_fresh = 1'b1;
        endcase

        if (do_ext)
        begin
            if (mode_next == MODE_IDENT) cand_next = filter(cand_next, len_next, ch);
            if (len_next < LEN_W'(MAX_LEN)) len_next = len_next + 1'b1;
            else                            ovf_next = 1'b1;
        end

        if (do_pend)
        begin
            res_kind[n]  = pending_kind(mode_next, ovf_next, cand_next, len_next);
            res_start[n] = start_next;
            res_len[n]   = len_next;
            res_tl[n]    = ovf_next;
            n            = n + 1'b1;
            mode_next    = MODE_IDLE;
            len_next     = '0;
            ovf_next     = 1'b0;
            cand_next    = kl_pkg::ALL_CANDIDATES;
        end

        if (do_fresh && !is_space(ch))
        begin
            ovf_next  = 1'b0;
            cand_next = kl_pkg::ALL_CANDIDATES;
            if (is_alpha(ch) || ch == kl_pkg::CH_UNDERSCORE)
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                cand_next  = filter(kl_pkg::ALL_CANDIDATES, '0, ch);
                len_next   = LEN_W'(1);
            end
            else if (is_digit(ch))
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = LEN_W'(1);
            end
            else if (ch == kl_pkg::CH_QUOTE)
            begin
                // string text starts after the opening quote
                mode_next  = MODE_STRING;
                start_next = pos_inc;
                len_next   = '0;
            end
            else
            begin
                res_kind[n]  = single_kind(ch);
                res_start[n] = pos_reg;
                res_len[n]   = LEN_W'(1);
                res_cv[n]    = ch;
                n            = n + 1'b1;
            end
        end

        if (final_byte)
        begin
            if (mode_next != MODE_IDLE)
            begin
                res_kind[n]  = pending_kind(mode_next, ovf_next, cand_next, len_next);
                res_start[n] = start_next;
                res_len[n]   = len_next;
                res_tl[n]    = ovf_next;
                n            = n + 1'b1;
            end
            res_kind[n]  = kl_pkg::KIND_EOF;
            res_start[n] = pos_inc;
            n            = n + 1'b1;
            mode_next    = MODE_IDLE;
            start_next   = '0;
            len_next     = '0;
            ovf_next     = 1'b0;
            cand_next    = kl_pkg::ALL_CANDIDATES;
            pos_next     = '0;
        end

        res_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            cand_reg  <= kl_pkg::ALL_CANDIDATES;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
        end
    end

endmodule

FILE: rtl/core/kl_res_buf.sv
// result register that holds the tokens of one byte and hands them out in order
`timescale 1ns / 1ps

module kl_res_buf #(
    parameter int POS_W = 20,
    parameter int LEN_W = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                res_count,
    input  logic [kl_pkg::KIND_W-1:0] res_kind  [kl_pkg::MAX_RES],
    input  logic [POS_W-1:0]          res_start [kl_pkg::MAX_RES],
    input  logic [LEN_W-1:0]          res_len   [kl_pkg::MAX_RES],
    input  logic [7:0]                res_cv    [kl_pkg::MAX_RES],
    input  logic                      res_tl    [kl_pkg::MAX_RES],
    kl_token_if.source                tok_out
);

    logic [kl_pkg::KIND_W-1:0] kind_reg  [kl_pkg::MAX_RES];
    logic [POS_W-1:0]          start_reg [kl_pkg::MAX_RES];
    logic [LEN_W-1:0]          len_reg   [kl_pkg::MAX_RES];
    logic [7:0]                cv_reg    [kl_pkg::MAX_RES];
    logic                      tl_reg    [kl_pkg::MAX_RES];
    logic [1:0]                rem_reg;
    logic [1:0]                rd_reg;
    logic                      out_xfer;
    logic                      load;

    assign out_xfer = tok_out.valid && tok_out.ready;
    // take a new byte when no token waits or the last waiting token leaves in this cycle
    assign in_ready = (rem_reg == 2'd0) || (rem_reg == 2'd1 && tok_out.ready);
    assign load     = in_valid && in_ready;

    assign tok_out.valid      = (rem_reg != 2'd0);
    assign tok_out.kind       = kind_reg[rd_reg];
    assign tok_out.start_res  = start_reg[rd_reg];
    assign tok_out.length     = len_reg[rd_reg];
    assign tok_out.char_value = cv_reg[rd_reg];
    assign tok_out.too_long   = tl_reg[rd_reg];
    assign tok_out.run_end    = (rem_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else if (load)
        begin
            rem_reg <= res_count;
            rd_reg  <= 2'd0;
        end
        else if (out_xfer)
        begin
            rem_reg <= rem_reg - 1'b1;
            if (rem_reg != 2'd1) rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= res_kind;
            start_reg <= res_start;
            len_reg   <= res_len;
            cv_reg    <= res_cv;
            tl_reg    <= res_tl;
        end
    end

endmodule

FILE: rtl/core/keyword_lexer_top.sv
// keyword lexer: source bytes in, tokens out
// byte_in carries one source byte per transfer with final_byte marking the end
// of the source. tok_out carries one token per transfer: kind, start offset,
// length (saturating at MAX_TOKEN_LEN, too_long set beyond it), char_value for
// operator and unknown tokens, and run_end on the last token of a byte.
// a byte is classified in the cycle it is taken; its tokens (zero to three)
// sit in the result register and appear on tok_out from the next cycle on,
// one per cycle while tok_out is ready. throughput is one byte per cycle
// while each byte gives at most one token and tok_out is ready; a byte that
// gives two or three tokens holds byte_in until its last token is taken, as
// there is a single token output port. an identifier or number is finished
// by the byte that follows it, so its token leaves with that byte.
// reset clears the scanner to idle at offset zero and empties the result
// register. when tok_out stalls, tokens hold and byte_in stays low-ready
// until the last waiting token is taken. after a final byte the scanner
// returns to its reset state and offsets restart at zero.
`timescale 1ns / 1ps

module keyword_lexer_top #(
    parameter int POSITION_BITS = 20,
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    kl_byte_if.sink    byte_in,
    kl_token_if.source tok_out
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    logic [1:0]                res_count;
    logic [kl_pkg::KIND_W-1:0] res_kind  [kl_pkg::MAX_RES];
    logic [POSITION_BITS-1:0]  res_start [kl_pkg::MAX_RES];
    logic [LEN_W-1:0]          res_len   [kl_pkg::MAX_RES];
    logic [7:0]                res_cv    [kl_pkg::MAX_RES];
    logic                      res_tl    [kl_pkg::MAX_RES];
    logic                      in_ready;
    logic                      accept;

    assign byte_in.ready = in_ready;
    assign accept        = byte_in.valid && in_ready;

    kl_scanner #(
        .POS_W   (POSITION_BITS),
        .MAX_LEN (MAX_TOKEN_LEN),
        .LEN_W   (LEN_W)
    ) u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .ch         (byte_in.ch),
        .final_byte (byte_in.final_byte),
        .res_count  (res_count),
        .res_kind   (res_kind),
        .res_start  (res_start),
        .res_len    (res_len),
        .res_cv     (res_cv),
        .res_tl     (res_tl)
    );

    kl_res_buf #(
        .POS_W (POSITION_BITS),
        .LEN_W (LEN_W)
    ) u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_in.valid),
        .in_ready  (in_ready),
        .res_count (res_count),
        .res_kind  (res_kind),
        .res_start (res_start),
        .res_len   (res_len),
        .res_cv    (res_cv),
        .res_tl    (res_tl),
        .tok_out   (tok_out)
    );

endmodule

FILE: rtl/core/kl_checker.sv
// port-level checks for the keyword lexer, bound to the top level
`timescale 1ns / 1ps

module kl_checker #(
    parameter int MAX_LEN = 255,
    parameter int LEN_W   = 8
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [kl_pkg::KIND_W-1:0] kind,
    input logic [LEN_W-1:0]          length,
    input logic                      too_long,
    input logic                      run_end
);

    // a waiting token is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token withdrawn while stalled");

    // end of file is always the last token of its byte
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == kl_pkg::KIND_EOF |-> run_end)
        else $error("eof token not last of its run");

    a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == kl_pkg::KIND_EOF |-> length == '0 && !too_long)
        else $error("eof token with nonzero length");

    a_sat_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_long |-> length == LEN_W'(MAX_LEN))
        else $error("overlong token length not saturated");

    // no new byte is taken while more than one token still waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_end |-> !in_ready)
        else $error("byte taken with tokens pending");

endmodule

bind keyword_lexer_top kl_checker #(
    .MAX_LEN (MAX_TOKEN_LEN),
    .LEN_W   ($clog2(MAX_TOKEN_LEN + 1))
) u_kl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (byte_in.ready),
    .out_valid (tok_out.valid),
    .out_ready (tok_out.ready),
    .kind      (tok_out.kind),
    .length    (tok_out.length),
    .too_long  (tok_out.too_long),
    .run_end   (tok_out.run_end)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench for keyword_lexer_top: directed rows, then random token streams
`timescale 1ns / 1ps

module tb_top;

    localparam int POS_BITS  = 20;
    localparam int MAX_LEN   = 255;
    localparam int WDOG_MAX  = 5000;
    localparam int MAX_SHOWN = 10;

    localparam string KW_WORDS [6] = '{"func", "main", "print", "var", "if", "while"};
    localparam string OP_LIST = "(){};,=+-*/";

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING} scan_mode_t;

    typedef struct packed {
        logic [kl_pkg::KIND_W-1:0] kind;
        logic [POS_BITS-1:0]       start;
        logic [7:0]                len;
        logic [7:0]                cv;
        logic                      too_long;
        logic                      run_end;
    } token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        token_t     want;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } src_byte_t;

    // rows with a typed token are checked against it, the rest against the scanner model
    localparam stim_row_t DIRECTED [20] = '{
        '{"(",   1'b0, 1'b1, '{kl_pkg::KIND_OP_BASE, 20'd0, 8'd1, "(", 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{kl_pkg::KIND_UNKNOWN, 20'd1, 8'd1, 8'hFF, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b1, '{kl_pkg::KIND_UNKNOWN, 20'd2, 8'd1, 8'h00, 1'b0, 1'b1}},
        '{"i",   1'b0, 1'b0, '0},
        '{"f",   1'b0, 1'b0, '0},
        '{" ",   1'b0, 1'b0, '0},
        '{"x",   1'b0, 1'b0, '0},
        '{"9",   1'b0, 1'b0, '0},
        '{"_",   1'b0, 1'b0, '0},
        '{"+",   1'b0, 1'b0, '0},
        '{"4",   1'b0, 1'b0, '0},
        '{"2",   1'b0, 1'b0, '0},
        '{kl_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{kl_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{kl_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{"a",   1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{"b",   1'b1, 1'b0, '0},
        '{" ",   1'b1, 1'b1, '{kl_pkg::KIND_EOF, 20'd1, 8'd0, 8'h00, 1'b0, 1'b1}},
        '{"/",   1'b1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    kl_byte_if byte_ch ();
    kl_token_if #(.POS_W(POS_BITS), .LEN_W(8)) tok_ch ();

    keyword_lexer_top #(
        .POSITION_BITS(POS_BITS),
        .MAX_TOKEN_LEN(MAX_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .tok_out (tok_ch)
    );

    always #5 clk = ~clk;

    // scanner model state
    scan_mode_t          lex_mode;
    logic [POS_BITS-1:0] tok_start;
    int                  tok_len;
    logic                tok_over;
    logic [POS_BITS-1:0] byte_pos;
    logic [5:0]          kw_live;

    token_t    step_tokens[$];
    token_t    pending_tokens[$];
    src_byte_t src_bytes[$];

    int sender_idle_pct;
    int recv_stall_pct;
    int error_count;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic reset_scanner();
        lex_mode  = SCAN_IDLE;
        tok_start = '0;
        tok_len   = 0;
        tok_over  = 1'b0;
        byte_pos  = '0;
        kw_live   = '1;
    endtask

    task automatic push_token(logic [kl_pkg::KIND_W-1:0] kind, logic [POS_BITS-1:0] start,
                              logic [7:0] len, logic [7:0] cv, logic tl);
        token_t t;
        t = '{kind, start, len, cv, tl, 1'b0};
        step_tokens.push_back(t);
    endtask

    task automatic grow_token(logic [7:0] c);
        if (lex_mode == SCAN_IDENT)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (kw_live[k] && (tok_len >= KW_WORDS[k].len() || KW_WORDS[k][tok_len] != c))
                    kw_live[k] = 1'b0;
            end
        end
        if (tok_len < MAX_LEN)
            tok_len++;
        else
            tok_over = 1'b1;
    endtask

    task automatic flush_token();
        logic [kl_pkg::KIND_W-1:0] kind;
        kind = kl_pkg::KIND_STRING;
        if (lex_mode == SCAN_NUMBER)
            kind = kl_pkg::KIND_NUMBER;
        else if (lex_mode == SCAN_IDENT)
        begin
            kind = kl_pkg::KIND_IDENT;
            if (!tok_over)
            begin
                for (int k = 0; k < 6; k++)
                    if (kw_live[k] && KW_WORDS[k].len() == tok_len)
                        kind = kl_pkg::KIND_W'(k);
            end
        end
        push_token(kind, tok_start, tok_len[7:0], 8'h00, tok_over);
        lex_mode = SCAN_IDLE;
        tok_len  = 0;
        tok_over = 1'b0;
        kw_live  = '1;
    endtask

    task automatic start_token(logic [7:0] c, logic [POS_BITS-1:0] pos);
        bit hit;
        hit = 1'b0;
        if (is_space(c))
            return;
        tok_over = 1'b0;
        kw_live  = '1;
        if (is_alpha(c) || c == kl_pkg::CH_UNDERSCORE || is_digit(c))
        begin
            lex_mode  = is_digit(c) ? SCAN_NUMBER : SCAN_IDENT;
            tok_start = pos;
            tok_len   = 0;
            grow_token(c);
        end
        else if (c == kl_pkg::CH_QUOTE)
        begin
            lex_mode  = SCAN_STRING;
            tok_start = pos + 1'b1;
            tok_len   = 0;
        end
        else
        begin
            for (int k = 0; k < OP_LIST.len(); k++)
            begin
                if (!hit && OP_LIST[k] == c)
                begin
                    push_token(kl_pkg::KIND_OP_BASE + kl_pkg::KIND_W'(k), pos, 8'd1, c, 1'b0);
                    hit = 1'b1;
                end
            end
            if (!hit)
                push_token(kl_pkg::KIND_UNKNOWN, pos, 8'd1, c, 1'b0);
        end
    endtask

    // tokens caused by one source byte, left in step_tokens
    task automatic scan_byte(logic [7:0] c, logic fin);
        logic [POS_BITS-1:0] pos;
        pos = byte_pos;
        step_tokens.delete();
        case (lex_mode)
            SCAN_IDENT:
            begin
                if (is_alpha(c) || is_digit(c) || c == kl_pkg::CH_UNDERSCORE)
                    grow_token(c);
                else
                begin
                    flush_token();
                    start_token(c, pos);
                end
            end
            SCAN_NUMBER:
            begin
                if (is_digit(c))
                    grow_token(c);
                else
                begin
                    flush_token();
                    start_token(c, pos);
                end
            end
            SCAN_STRING:
            begin
                if (c == kl_pkg::CH_QUOTE)
                    flush_token();
                else
                    grow_token(c);
            end
            default:
                start_token(c, pos);
        endcase
        if (fin)
        begin
            if (lex_mode != SCAN_IDLE)
                flush_token();
            push_token(kl_pkg::KIND_EOF, pos + 1'b1, 8'd0, 8'h00, 1'b0);
            reset_scanner();
        end
        else
            byte_pos = pos + 1'b1;
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].run_end = 1'b1;
    endtask

    task automatic send_byte(logic [7:0] c, logic fin, logic typed, token_t want);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.ch         <= c;
        byte_ch.final_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        scan_byte(c, fin);
        if (typed)
            pending_tokens.push_back(want);
        else
            foreach (step_tokens[i])
                pending_tokens.push_back(step_tokens[i]);
    endtask

    function automatic logic [7:0] rand_ident_char();
        int r;
        r = $urandom_range(62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return kl_pkg::CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] rand_non_quote();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == kl_pkg::CH_QUOTE) ? 8'h27 : b;
    endfunction

    task automatic queue_byte(logic [7:0] c);
        src_bytes.push_back('{c, 1'b0});
    endtask

    task automatic add_fragment();
        int    r;
        int    n;
        string w;
        r = $urandom_range(99);
        if (r < 20)
        begin
            // keyword, sometimes cut short or extended into a plain identifier
            w = KW_WORDS[$urandom_range(5)];
            n = ($urandom_range(9) == 0) ? $urandom_range(1, w.len() - 1) : w.len();
            for (int i = 0; i < n; i++)
                queue_byte(w[i]);
            if ($urandom_range(6) == 0)
                queue_byte(rand_ident_char());
        end
        else if (r < 35)
        begin
            queue_byte($urandom_range(4) == 0 ? kl_pkg::CH_UNDERSCORE
                       : 8'("a" + $urandom_range(25) - ($urandom_range(1) ? 32 : 0)));
            n = $urandom_range(7);
            for (int i = 0; i < n; i++)
                queue_byte(rand_ident_char());
        end
        else if (r < 47)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                queue_byte(8'("0" + $urandom_range(9)));
        end
        else if (r < 57)
        begin
            queue_byte(kl_pkg::CH_QUOTE);
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
                queue_byte(rand_non_quote());
            if ($urandom_range(6) != 0)
                queue_byte(kl_pkg::CH_QUOTE);
        end
        else if (r < 72)
            queue_byte(OP_LIST[$urandom_range(OP_LIST.len() - 1)]);
        else if (r < 87)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                queue_byte($urandom_range(5) == 0 ? " " : 8'($urandom_range(9, 13)));
        end
        else
            queue_byte(8'($urandom_range(255)));
        if ($urandom_range(29) == 0)
            src_bytes[src_bytes.size() - 1].fin = 1'b1;
    endtask

    // token side: ready pattern and result checks
    initial
    begin
        tok_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            got = '{tok_ch.kind, tok_ch.start_res, tok_ch.length, tok_ch.char_value,
                    tok_ch.too_long, tok_ch.run_end};
            if (pending_tokens.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("tb_top: unexpected token kind %0d start %0d len %0d char %02h",
                             got.kind, got.start, got.len, got.cv);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.len !== want.len || got.cv !== want.cv ||
                    got.too_long !== want.too_long || got.run_end !== want.run_end)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display({"tb_top: token mismatch at %0t (kind/start/len/char/",
                                  "too_long/run_end): expected %0d/%0d/%0d/%02h/%0b/%0b, ",
                                  "got %0d/%0d/%0d/%02h/%0b/%0b"},
                                 $time, want.kind, want.start, want.len, want.cv,
                                 want.too_long, want.run_end, got.kind, got.start, got.len,
                                 got.cv, got.too_long, got.run_end);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WDOG_MAX)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        src_byte_t b;
        byte_ch.valid      = 1'b0;
        byte_ch.ch         = 8'h00;
        byte_ch.final_byte = 1'b0;
        sender_idle_pct    = 0;
        recv_stall_pct     = 0;
        error_count        = 0;
        rst_n              = 1'b0;
        reset_scanner();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].ch, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 88;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 88;
                end
                default:
                begin
                    sender_idle_pct = 16;
                    recv_stall_pct  = 16;
                end
            endcase
            src_bytes.delete();
            while (src_bytes.size() < 55)
                add_fragment();
            // close the phase so the scanner is back at offset zero
            src_bytes[src_bytes.size() - 1].fin = 1'b1;
            while (src_bytes.size() > 0)
            begin
                b = src_bytes.pop_front();
                send_byte(b.ch, b.fin, 1'b0, '0);
            end
        end

        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
